// File: rtl/snap_limited_speed_reference_macros.svh
`ifndef SNAP_LIMITED_SPEED_REFERENCE_MACROS_SVH
`define SNAP_LIMITED_SPEED_REFERENCE_MACROS_SVH

// same-cycle implication, checked on clk, off while rst is high
`define SLSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/slsr_pkg.sv
package slsr_pkg;

  localparam int DATA_W     = 32;
  localparam int OPA_W      = 33;
  localparam int GAIN_W     = 26;
  localparam int PROD_W     = OPA_W + GAIN_W + 1;
  localparam int CLAMP_W    = 44;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int POLE_W     = 24;
  localparam int TIME_W     = 24;
  localparam int LIM_W      = 31;
  localparam int KV_W       = 23;

  localparam int FRAC_SHIFT   = 16;
  localparam int TIME_SHIFT   = 24;
  localparam int RECIP3_SHIFT = 25;

  // (2^25 + 1) / 3: floor(p * RECIP3 >> 25) == floor(p / 3) for any 24-bit p
  localparam logic [GAIN_W-1:0] RECIP3        = 26'd11184811;
  localparam logic [TIME_W-1:0] STEP_TIME_RST = 24'd1678;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE,
    CFG_STEP_TIME,
    CFG_ACCEL_LIMIT,
    CFG_JERK_LIMIT,
    CFG_SNAP_LIMIT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STEP_KV,
    STEP_VEL,
    STEP_ACC,
    STEP_JRK,
    STEP_INT_J,
    STEP_INT_A,
    STEP_INT_S
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_POST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  diff;
    logic  mul;
    logic  post;
    logic  out_load;
    step_t step;
  } ctrl_t;

  function automatic logic signed [DATA_W-1:0] clamp_lim(
    input logic signed [CLAMP_W-1:0] x,
    input logic        [LIM_W-1:0]   lim
  );
    logic signed [CLAMP_W-1:0] hi;
    logic signed [CLAMP_W-1:0] lo;
    hi = $signed({{(CLAMP_W-LIM_W){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      return DATA_W'(hi);
    end else if (x < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(x);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_word(
    input logic signed [CLAMP_W-1:0] x
  );
    logic signed [CLAMP_W-1:0] hi;
    logic signed [CLAMP_W-1:0] lo;
    hi = $signed({{(CLAMP_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
    lo = -hi - CLAMP_W'(1);
    if (x > hi) begin
      return DATA_W'(hi);
    end else if (x < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(x);
  endfunction

endpackage

// File: rtl/slsr_seq.sv
module slsr_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            command,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output slsr_pkg::ctrl_t ctrl
);

  slsr_pkg::state_t state;
  slsr_pkg::state_t state_next;
  slsr_pkg::step_t  step;
  slsr_pkg::step_t  step_succ;

  always_comb begin
    unique case (step)
      slsr_pkg::STEP_KV:    step_succ = slsr_pkg::STEP_VEL;
      slsr_pkg::STEP_VEL:   step_succ = slsr_pkg::STEP_ACC;
      slsr_pkg::STEP_ACC:   step_succ = slsr_pkg::STEP_JRK;
      slsr_pkg::STEP_JRK:   step_succ = slsr_pkg::STEP_INT_J;
      slsr_pkg::STEP_INT_J: step_succ = slsr_pkg::STEP_INT_A;
      slsr_pkg::STEP_INT_A: step_succ = slsr_pkg::STEP_INT_S;
      default:              step_succ = slsr_pkg::STEP_KV;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      slsr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = command ? slsr_pkg::ST_DONE : slsr_pkg::ST_MUL;
        end
      end
      slsr_pkg::ST_DIFF: state_next = slsr_pkg::ST_MUL;
      slsr_pkg::ST_MUL:  state_next = slsr_pkg::ST_POST;
      slsr_pkg::ST_POST: begin
        if (step == slsr_pkg::STEP_INT_S) begin
          state_next = slsr_pkg::ST_DONE;
        end else if (step_succ == slsr_pkg::STEP_ACC || step_succ == slsr_pkg::STEP_JRK) begin
          // these steps take a difference of fresh values first
          state_next = slsr_pkg::ST_DIFF;
        end else begin
          state_next = slsr_pkg::ST_MUL;
        end
      end
      slsr_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = slsr_pkg::ST_IDLE;
        end
      end
      default: state_next = slsr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state != slsr_pkg::ST_IDLE);
    ctrl.load     = (state == slsr_pkg::ST_IDLE) && in_valid;
    ctrl.diff     = (state == slsr_pkg::ST_DIFF);
    ctrl.mul      = (state == slsr_pkg::ST_MUL);
    ctrl.post     = (state == slsr_pkg::ST_POST);
    ctrl.out_load = (state == slsr_pkg::ST_DONE) && (!out_valid || !out_stall);
    ctrl.step     = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slsr_pkg::ST_IDLE;
      step      <= slsr_pkg::STEP_KV;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        step <= slsr_pkg::STEP_KV;
      end else if (ctrl.post && step != slsr_pkg::STEP_INT_S) begin
        step <= step_succ;
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/slsr_mul.sv
module slsr_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [slsr_pkg::OPA_W-1:0]    opa,
  input  logic        [slsr_pkg::GAIN_W-1:0]   gain,
  output logic signed [slsr_pkg::PROD_W-1:0]   prod
);

  // gain is unsigned, so widen it with a zero sign bit
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= opa * $signed({1'b0, gain});
    end
  end

endmodule

// File: rtl/slsr_dp.sv
module slsr_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  slsr_pkg::ctrl_t                        ctrl,
  input  logic                                   command,
  input  logic signed [slsr_pkg::DATA_W-1:0]     target_value,
  input  logic                                   cfg_we,
  input  logic        [slsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [slsr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [slsr_pkg::PROD_W-1:0]     prod,
  output logic signed [slsr_pkg::OPA_W-1:0]      opa,
  output logic        [slsr_pkg::GAIN_W-1:0]     gain,
  output logic signed [slsr_pkg::DATA_W-1:0]     shaped_speed
);

  localparam int DW = slsr_pkg::DATA_W;
  localparam int OW = slsr_pkg::OPA_W;
  localparam int GW = slsr_pkg::GAIN_W;
  localparam int CW = slsr_pkg::CLAMP_W;

  logic [slsr_pkg::POLE_W-1:0] pole;
  logic [slsr_pkg::TIME_W-1:0] step_time;
  logic [slsr_pkg::LIM_W-1:0]  accel_lim;
  logic [slsr_pkg::LIM_W-1:0]  jerk_lim;
  logic [slsr_pkg::LIM_W-1:0]  snap_lim;
  logic [GW-1:0]               kj;
  logic [slsr_pkg::KV_W-1:0]   kv;

  logic signed [DW-1:0] speed;
  logic signed [DW-1:0] accel;
  logic signed [DW-1:0] jerk;
  logic signed [DW-1:0] target;
  logic signed [DW-1:0] des;

  logic signed [CW-1:0] prod_q16;
  logic signed [CW-1:0] prod_q24;
  logic signed [DW-1:0] lim_vel;
  logic signed [DW-1:0] lim_acc;
  logic signed [DW-1:0] lim_snap;
  logic signed [DW-1:0] jerk_new;
  logic signed [DW-1:0] accel_new;
  logic signed [DW-1:0] speed_new;
  logic [GW-1:0]        pole_x1;

  // arithmetic shifts give floor rounding
  assign prod_q16 = CW'(prod >>> slsr_pkg::FRAC_SHIFT);
  assign prod_q24 = CW'(prod >>> slsr_pkg::TIME_SHIFT);

  assign lim_vel   = slsr_pkg::clamp_lim(prod_q16, accel_lim);
  assign lim_acc   = slsr_pkg::clamp_lim(prod_q16, jerk_lim);
  assign lim_snap  = slsr_pkg::clamp_lim(prod_q16, snap_lim);
  assign jerk_new  = slsr_pkg::clamp_lim(CW'(jerk) + prod_q24, jerk_lim);
  assign accel_new = slsr_pkg::clamp_lim(CW'(accel) + prod_q24, accel_lim);
  assign speed_new = slsr_pkg::sat_word(CW'(speed) + prod_q24);

  assign pole_x1 = GW'(cfg_data[slsr_pkg::POLE_W-1:0]);

  always_comb begin
    unique case (ctrl.step)
      slsr_pkg::STEP_KV:    gain = slsr_pkg::RECIP3;
      slsr_pkg::STEP_VEL:   gain = GW'(kv);
      slsr_pkg::STEP_ACC:   gain = GW'(pole);
      slsr_pkg::STEP_JRK:   gain = kj;
      slsr_pkg::STEP_INT_J: gain = GW'(step_time);
      slsr_pkg::STEP_INT_A: gain = GW'(step_time);
      slsr_pkg::STEP_INT_S: gain = GW'(step_time);
      default:              gain = '0;
    endcase
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      pole      <= '0;
      step_time <= slsr_pkg::STEP_TIME_RST;
      accel_lim <= '0;
      jerk_lim  <= '0;
      snap_lim  <= '0;
      kj        <= '0;
      speed     <= '0;
      accel     <= '0;
      jerk      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (slsr_pkg::cfg_idx_t'(cfg_index))
          slsr_pkg::CFG_POLE: begin
            pole <= cfg_data[slsr_pkg::POLE_W-1:0];
            kj   <= pole_x1 + (pole_x1 << 1);
          end
          slsr_pkg::CFG_STEP_TIME:   step_time <= cfg_data[slsr_pkg::TIME_W-1:0];
          slsr_pkg::CFG_ACCEL_LIMIT: accel_lim <= cfg_data[slsr_pkg::LIM_W-1:0];
          slsr_pkg::CFG_JERK_LIMIT:  jerk_lim  <= cfg_data[slsr_pkg::LIM_W-1:0];
          slsr_pkg::CFG_SNAP_LIMIT:  snap_lim  <= cfg_data[slsr_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.load && command) begin
        speed <= target_value;
        accel <= '0;
        jerk  <= '0;
      end
      if (ctrl.post) begin
        unique case (ctrl.step)
          slsr_pkg::STEP_INT_J: jerk  <= jerk_new;
          slsr_pkg::STEP_INT_A: accel <= accel_new;
          slsr_pkg::STEP_INT_S: speed <= speed_new;
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      target <= target_value;
      opa    <= OW'(pole);
    end
    if (ctrl.diff) begin
      unique case (ctrl.step)
        slsr_pkg::STEP_ACC: opa <= OW'(des) - OW'(accel);
        slsr_pkg::STEP_JRK: opa <= OW'(des) - OW'(jerk);
        default: ;
      endcase
    end
    if (ctrl.post) begin
      unique case (ctrl.step)
        slsr_pkg::STEP_KV: begin
          kv  <= prod[slsr_pkg::RECIP3_SHIFT +: slsr_pkg::KV_W];
          opa <= OW'(target) - OW'(speed);
        end
        slsr_pkg::STEP_VEL:   des <= lim_vel;
        slsr_pkg::STEP_ACC:   des <= lim_acc;
        slsr_pkg::STEP_JRK:   opa <= OW'(lim_snap);
        slsr_pkg::STEP_INT_J: opa <= OW'(jerk_new);
        slsr_pkg::STEP_INT_A: opa <= OW'(accel_new);
        default: ;
      endcase
    end
    if (ctrl.out_load) begin
      shaped_speed <= speed;
    end
  end

endmodule

// File: rtl/snap_limited_speed_reference.sv
// Snap-limited speed reference shaper.
// Input channel (in_valid / in_stall): command 0 moves the reference one
// sample toward target_value; command 1 loads speed with target_value and
// zeroes acceleration and jerk. Each beat yields one shaped_speed beat on
// the output channel (out_valid / out_stall).
// A reset-command beat skips the multiplications and goes straight to the
// output register. No new beat is taken before the previous one's result
// has been loaded into the output register.
// The seven multiplications of an update (1/3 of the pole, three gain
// products, three time integrations) all go through one registered
// 33x26 multiplier, one after another.
// in_stall is high from acceptance until the result sits in the output
// register. When the receiver stalls, the finished result waits there
// and the block holds its work until the register frees up.
// Configuration (cfg_valid / cfg_ready, always ready) writes the pole, step
// time and limits; write only while idle. Unknown indexes are ignored.
// Reset (rst, synchronous) zeroes speed, acceleration, jerk and the limits,
// and drops any pending result.
module snap_limited_speed_reference (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   command,
  input  logic signed [slsr_pkg::DATA_W-1:0]     target_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [slsr_pkg::DATA_W-1:0]     shaped_speed,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [slsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [slsr_pkg::CFG_DATA_W-1:0] cfg_data
);

  slsr_pkg::ctrl_t                       ctrl;
  logic signed [slsr_pkg::OPA_W-1:0]     opa;
  logic        [slsr_pkg::GAIN_W-1:0]    gain;
  logic signed [slsr_pkg::PROD_W-1:0]    prod;

  assign cfg_ready = 1'b1;

  slsr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  slsr_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul),
    .opa  (opa),
    .gain (gain),
    .prod (prod)
  );

  slsr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (command),
    .target_value (target_value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .prod         (prod),
    .opa          (opa),
    .gain         (gain),
    .shaped_speed (shaped_speed)
  );

endmodule

// File: rtl/slsr_chk.sv
`include "snap_limited_speed_reference_macros.svh"

module slsr_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   command,
  input logic signed [slsr_pkg::DATA_W-1:0]     target_value,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [slsr_pkg::DATA_W-1:0]     shaped_speed
);

  // one item at a time: a beat in closes the input until its result is out
  `SLSR_ASSERT_NXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "input open while busy")

  // no result can appear on the cycle right after a beat
  `SLSR_ASSERT_NXT(a_no_early_result, in_valid && !in_stall && !out_valid, !out_valid, "result too early")

  // a reset command shows the loaded speed via the speed register, then the output register
  `SLSR_ASSERT_IMP(a_reset_cmd, in_valid && !in_stall && command && !out_valid, ##2 (out_valid && shaped_speed == $past(target_value, 2)), "reset speed not shown")

  `SLSR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(shaped_speed), "stalled result changed")

endmodule

bind snap_limited_speed_reference slsr_chk u_chk (.*);

// File: bench/snap_limited_speed_reference_test.sv
module snap_limited_speed_reference_test;
  import slsr_pkg::*;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_SNAP_LIMIT + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
  localparam int NUM_REGS = CFG_SNAP_LIMIT + 1;

  localparam int     CYCLE_LIMIT = 500000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     TAIL_CYCLES = 40;
  localparam longint SPEED_MAX   = 64'sd2147483647;
  localparam longint SPEED_MIN   = -64'sd2147483648;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     command;
  logic signed [DATA_W-1:0] target_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] shaped_speed;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  snap_limited_speed_reference uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .target_value (target_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .shaped_speed (shaped_speed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // shaper state and register copies
  logic [POLE_W-1:0] pole_r;
  logic [TIME_W-1:0] tstep_r;
  logic [LIM_W-1:0]  alim_r;
  logic [LIM_W-1:0]  jlim_r;
  logic [LIM_W-1:0]  slim_r;
  longint            speed_st;
  longint            accel_st;
  longint            jerk_st;

  logic signed [DATA_W-1:0] speed_due_q [$];

  int   fault_count   = 0;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_go       = 1'b0;
  logic hold_on       = 1'b0;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 cmd;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic                 lit_ok;
    logic [31:0]          lit;
  } dir_row_t;

  dir_row_t dir_rows [32] = '{
    // zero limits after reset: an update never moves the speed
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b1, 32'h00000000},
    '{ROW_ITEM, CMD_LOAD,   '0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h80000000, 1'b1, 32'h7FFFFFFF},
    '{ROW_ITEM, CMD_LOAD,   '0, 32'h80000000, 1'b1, 32'h80000000},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h00000000, 1'b1, 32'h80000000},
    // everything at full scale, upper data bits beyond field width set
    '{ROW_CFG,  CMD_UPDATE, CFG_POLE,        32'hFFFFFFFF, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_STEP_TIME,   32'hFFFFFFFF, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_ACCEL_LIMIT, 32'hFFFFFFFF, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_JERK_LIMIT,  32'hFFFFFFFF, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_SNAP_LIMIT,  32'hFFFFFFFF, 1'b0, '0},
    // drive speed into both saturation rails
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h80000000, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h80000000, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h80000000, 1'b0, '0},
    // lower limits under large accel/jerk states
    '{ROW_CFG,  CMD_UPDATE, CFG_ACCEL_LIMIT, 32'h00010000, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_JERK_LIMIT,  32'h00000800, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h00000000, 1'b0, '0},
    // writes to unused indexes must not land anywhere
    '{ROW_CFG,  CMD_UPDATE, CFG_SPARE_LO, 32'h00000000, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_SPARE_HI, 32'h00000000, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h12345678, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_SNAP_LIMIT, 32'h00000000, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h40000000, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_POLE,       32'h00000000, 1'b0, '0},
    '{ROW_CFG,  CMD_UPDATE, CFG_STEP_TIME,  32'h00000000, 1'b0, '0},
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM, CMD_LOAD,   '0, 32'h00000000, 1'b1, 32'h00000000},
    '{ROW_ITEM, CMD_LOAD,   '0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    // zero pole: speed holds
    '{ROW_ITEM, CMD_UPDATE, '0, 32'h55555555, 1'b1, 32'hFFFFFFFF}
  };

  function automatic longint clip_to(longint x, logic [LIM_W-1:0] lim);
    longint l;
    l = longint'(lim);
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  function automatic logic signed [DATA_W-1:0] shape_speed(
    logic cmd, logic signed [DATA_W-1:0] tgt);
    longint kv, ka, kj, ts, acc_want, jerk_want, snap;
    ka = longint'(pole_r);
    kv = ka / 3;
    kj = ka * 3;
    ts = longint'(tstep_r);
    if (cmd == CMD_LOAD) begin
      speed_st = tgt;
      accel_st = 0;
      jerk_st  = 0;
    end else begin
      acc_want  = clip_to((kv * (longint'(tgt) - speed_st)) >>> FRAC_SHIFT, alim_r);
      jerk_want = clip_to((ka * (acc_want - accel_st)) >>> FRAC_SHIFT, jlim_r);
      snap      = clip_to((kj * (jerk_want - jerk_st)) >>> FRAC_SHIFT, slim_r);
      // newest first: jerk, then accel from new jerk, then speed
      jerk_st  = clip_to(jerk_st + ((snap * ts) >>> TIME_SHIFT), jlim_r);
      accel_st = clip_to(accel_st + ((jerk_st * ts) >>> TIME_SHIFT), alim_r);
      speed_st = speed_st + ((accel_st * ts) >>> TIME_SHIFT);
      if (speed_st > SPEED_MAX) speed_st = SPEED_MAX;
      if (speed_st < SPEED_MIN) speed_st = SPEED_MIN;
    end
    return speed_st[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_speed();
    logic signed [DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(4))
      0: w = w >>> $urandom_range(4, 20);
      1: w = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: w = w >>> 12;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return $urandom >> $urandom_range(0, 20);
    endcase
  endfunction

  task automatic wait_results();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (speed_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLE:        pole_r  = data[POLE_W-1:0];
      CFG_STEP_TIME:   tstep_r = data[TIME_W-1:0];
      CFG_ACCEL_LIMIT: alim_r  = data[LIM_W-1:0];
      CFG_JERK_LIMIT:  jlim_r  = data[LIM_W-1:0];
      CFG_SNAP_LIMIT:  slim_r  = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(logic cmd, logic signed [DATA_W-1:0] val,
                           logic lit_ok, logic [DATA_W-1:0] lit);
    logic signed [DATA_W-1:0] due;
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    target_value <= val;
    do @(posedge clk); while (in_stall);
    due = shape_speed(cmd, val);
    speed_due_q.push_back(lit_ok ? lit : due);
  endtask

  task automatic setup_phase(int ph);
    logic [CFG_DATA_W-1:0] vals [NUM_REGS];
    int pf;
    wait_results();
    if (ph == 0) begin
      foreach (vals[i]) vals[i] = '1;
    end else if (ph == 1) begin
      foreach (vals[i]) vals[i] = '0;
    end else if (ph == 5) begin
      foreach (vals[i]) vals[i] = $urandom;
    end else begin
      // pole in 1..255 rad/s with step small enough for a stable loop
      pf = $urandom_range(1, 255);
      vals[CFG_POLE]        = (pf << FRAC_SHIFT) | $urandom_range(0, 16'hFFFF);
      vals[CFG_STEP_TIME]   = $urandom_range(1, 24'hFFFFFF / pf);
      vals[CFG_ACCEL_LIMIT] = pick_limit();
      vals[CFG_JERK_LIMIT]  = pick_limit();
      vals[CFG_SNAP_LIMIT]  = pick_limit();
    end
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), vals[i]);
    for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++) write_reg(CFG_IDX_W'(i), $urandom);
    case (ph % 4)
      0: begin send_idle_pct = 0;  stall_pct <= 0;  end
      1: begin send_idle_pct = 54; stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  stall_pct <= 54; end
      default: begin send_idle_pct = 6; stall_pct <= 6; end
    endcase
  endtask

  task automatic run_phase(int n);
    int left;
    int run;
    logic signed [DATA_W-1:0] goal;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 8) begin
        send_item(1'($urandom_range(1)), pick_speed(), 1'b0, '0);
        left--;
      end else begin
        // sender pause until the block has emptied out
        if ($urandom_range(99) < 4) wait_results();
        send_item(CMD_LOAD, pick_speed(), 1'b0, '0);
        left--;
        goal = pick_speed();
        run  = $urandom_range(4, 40);
        while (run > 0 && left > 0) begin
          if ($urandom_range(99) < 10) goal = pick_speed();
          send_item(CMD_UPDATE, goal, 1'b0, '0);
          run--;
          left--;
        end
      end
    end
  endtask

  // output side: check each beat against the oldest prediction
  always @(posedge clk) begin : result_check
    logic signed [DATA_W-1:0] due;
    if (!rst && out_valid && !out_stall) begin
      if (speed_due_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("shaped_speed beat with nothing pending: %0d (0x%08h)",
                   shaped_speed, shaped_speed);
      end else begin
        due = speed_due_q.pop_front();
        if (shaped_speed !== due) begin
          fault_count++;
          if (fault_count <= 10)
            $display("shaped_speed mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                     due, due, shaped_speed, shaped_speed);
        end
      end
    end
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    @(posedge hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, speed_due_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    command      <= CMD_UPDATE;
    target_value <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_POLE;
    cfg_data     <= '0;
    pole_r   = '0;
    tstep_r  = STEP_TIME_RST;
    alim_r   = '0;
    jlim_r   = '0;
    slim_r   = '0;
    speed_st = 0;
    accel_st = 0;
    jerk_st  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_results();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_item(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].lit_ok, dir_rows[r].lit);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      setup_phase(ph);
      if (ph == 2) hold_go <= 1'b1;
      run_phase(ph == 1 ? 60 : 260);
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
